/* rtl/rgm_pkg.sv */
// ----------------------------------------------------------------------------
// rgm_pkg
// shared constants for the roberts gradient magnitude block
// ----------------------------------------------------------------------------
package rgm_pkg;

  // width of the magnitude result in quarter units
  localparam int MAG_W = 11;

  // width of the line width configuration register
  localparam int CFG_W = 13;

  // line width after reset
  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 13'd640;

endpackage

/* rtl/rgm_mag_calc.sv */
// ----------------------------------------------------------------------------
// rgm_mag_calc
// roberts cross differences and max + min/4 magnitude in quarter units
// ----------------------------------------------------------------------------
module rgm_mag_calc
  import rgm_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic [PIXEL_BITS-1:0] cur_pix,
  input  logic [PIXEL_BITS-1:0] upper_left_pix,
  input  logic [PIXEL_BITS-1:0] left_pix,
  input  logic [PIXEL_BITS-1:0] upper_pix,
  output logic [MAG_W-1:0]      magnitude
);

  localparam int FULL_W = PIXEL_BITS + 3;

  logic [PIXEL_BITS-1:0] diff_a;
  logic [PIXEL_BITS-1:0] diff_b;
  logic [PIXEL_BITS-1:0] hi_val;
  logic [PIXEL_BITS-1:0] lo_val;
  logic [FULL_W-1:0]     mag_full;

  // absolute differences along both diagonals
  assign diff_a = (cur_pix >= upper_left_pix) ? (cur_pix - upper_left_pix)
                                              : (upper_left_pix - cur_pix);
  assign diff_b = (left_pix >= upper_pix) ? (left_pix - upper_pix)
                                          : (upper_pix - left_pix);

  // larger and smaller of the two
  assign hi_val = (diff_a > diff_b) ? diff_a : diff_b;
  assign lo_val = (diff_a > diff_b) ? diff_b : diff_a;

  // 4*max + min
  assign mag_full  = (FULL_W'(hi_val) << 2) + FULL_W'(lo_val);
  assign magnitude = MAG_W'(mag_full);

endmodule

/* rtl/roberts_gradient_magnitude_top.sv */
// ----------------------------------------------------------------------------
// roberts_gradient_magnitude_top
// streaming roberts cross gradient magnitude with a one-row line store
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (valid/stall), one
// transaction per pixel; in_frame_start marks the first pixel of a frame.
// Every pixel gives exactly one result on the out_ channel: the gradient
// magnitude max(|a|,|b|) + min(|a|,|b|)/4 in quarter units, plus line_end on
// the last pixel of each row. Pixels outside the image count as zero.
// Throughput is one pixel per cycle while the receiver does not stall: the
// line store is a single-port-style memory read and written once per pixel
// at the accept edge. Two register stages: the accept edge loads stage 1 and
// the line store read, and the magnitude then moves into the output register
// once that register is free. When the receiver stalls, the output
// register and the stage behind it hold, and in_stall rises only once both
// are full. The row width is written through the cfg_ channel while idle;
// 0 acts as 1 and values above MAX_WIDTH act as MAX_WIDTH. After reset the
// width is 640 and the next pixel starts the first row of a frame. The line
// store has no clearing pass: its read is ignored in the first row of a frame.
// ----------------------------------------------------------------------------
module roberts_gradient_magnitude_top
  import rgm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic                  in_frame_start,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MAG_W-1:0]      out_magnitude_quarters,
  output logic                  out_line_end,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_line_width
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // configuration and column state
  logic [CFG_W-1:0]      line_width_r;
  logic [CW-1:0]         col_r;
  logic                  first_row_r;

  // stage 1: line store read in flight
  logic                  s1_valid_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic                  s1_first_r;
  logic                  s1_col0_r;
  logic                  s1_last_r;
  logic [PIXEL_BITS-1:0] rd_data_r;

  // neighbors from the previous pixel
  logic [PIXEL_BITS-1:0] left_r;
  logic [PIXEL_BITS-1:0] upper_left_r;

  // output register
  logic                  out_valid_r;
  logic [MAG_W-1:0]      out_mag_r;
  logic                  out_line_end_r;

  // line store
  logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

  logic [31:0]           lw_ext;
  logic [WW-1:0]         w_eff;
  logic [CW-1:0]         col_start;
  logic                  first_start;
  logic [CW-1:0]         x_cur;
  logic                  x_last;
  logic                  in_acc;
  logic                  out_free;
  logic                  s1_adv;
  logic [PIXEL_BITS-1:0] up_pix;
  logic [PIXEL_BITS-1:0] ul_pix;
  logic [PIXEL_BITS-1:0] lf_pix;
  logic [MAG_W-1:0]      mag_val;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // effective width, clamped to 1..MAX_WIDTH
  assign lw_ext = 32'(line_width_r);
  assign w_eff  = (lw_ext == 32'd0)               ? WW'(1) :
                  (lw_ext > 32'(MAX_WIDTH))       ? WW'(MAX_WIDTH) :
                                                    WW'(lw_ext);

  // column of the incoming pixel
  assign col_start   = in_frame_start ? '0 : col_r;
  assign first_start = in_frame_start ? 1'b1 : first_row_r;
  assign x_cur       = (WW'(col_start) >= w_eff) ? CW'(w_eff - WW'(1)) : col_start;
  assign x_last      = (WW'(x_cur) + WW'(1)) >= w_eff;

  // config and column control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
      col_r        <= '0;
      first_row_r  <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_width_r <= cfg_line_width;
      end
      if (in_acc) begin
        col_r       <= x_last ? '0 : (x_cur + CW'(1));
        first_row_r <= x_last ? 1'b0 : first_start;
      end
    end
  end

  // line store: read old entry and write the new pixel in the same cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r       <= line_mem[x_cur];
      line_mem[x_cur] <= in_pixel;
    end
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_pixel;
      s1_first_r <= first_start;
      s1_col0_r  <= (x_cur == '0);
      s1_last_r  <= x_last;
    end
  end

  // neighbor selection with zero border
  assign up_pix = s1_first_r ? '0 : rd_data_r;
  assign ul_pix = s1_col0_r ? '0 : upper_left_r;
  assign lf_pix = s1_col0_r ? '0 : left_r;

  rgm_mag_calc #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mag_calc (
    .cur_pix        (s1_pix_r),
    .upper_left_pix (ul_pix),
    .left_pix       (lf_pix),
    .upper_pix      (up_pix),
    .magnitude      (mag_val)
  );

  // previous pixel and its upper neighbor
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_r       <= s1_pix_r;
      upper_left_r <= up_pix;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mag_r      <= mag_val;
      out_line_end_r <= s1_last_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_magnitude_quarters = out_mag_r;
  assign out_line_end           = out_line_end_r;

  // a row end sends the column back to zero
  a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && x_last) |=> (col_r == '0))
    else $error("column not cleared after row end");

  // a frame start that is not a row end leaves the block in the first row
  a_frame_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_start && !x_last) |=> first_row_r)
    else $error("first row flag lost after frame start");

  // a pixel waiting behind a full output register keeps its data
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_pix_r) && $stable(rd_data_r)))
    else $error("stage 1 changed while blocked");

  // a row end result always carries line_end into the output register
  a_line_end_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (out_valid_r && out_line_end_r))
    else $error("line end lost on the way out");

endmodule

/* tb/roberts_gradient_magnitude_top_test.sv */
// ----------------------------------------------------------------------------
// roberts_gradient_magnitude_top_test
// self-checking bench for the streaming roberts cross gradient magnitude block
// ----------------------------------------------------------------------------
// A directed table covers the extreme pixel values, frame start in mid-row,
// the out-of-range widths and a width change in mid-row. Random frames
// follow, at widths that are mostly small. A bit-true gradient predictor
// produces the expected result for every pixel. The receiver compares each
// result with the oldest expected one.
// Both sides idle at random. The line width is only rewritten while the
// block is drained.
// ----------------------------------------------------------------------------
module roberts_gradient_magnitude_top_test;
  import rgm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W        = 8;
  localparam int ROW_MAX      = 4096;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [MAG_W-1:0] magnitude_quarters;
    logic             line_end;
  } gradient_t;

  typedef enum logic {ROW_PIXEL, ROW_WIDTH} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CFG_W-1:0] value;
    logic             frame_start;
    bit               typed;
    logic [MAG_W-1:0] magnitude_quarters;
    logic             line_end;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel;
  logic             in_frame_start;
  logic             out_valid;
  logic             out_stall;
  logic [MAG_W-1:0] out_magnitude_quarters;
  logic             out_line_end;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_line_width;

  // gradient predictor state
  logic [CFG_W-1:0] width_reg;
  logic [PIX_W-1:0] row_mem [ROW_MAX];
  bit               row_written [ROW_MAX];
  int unsigned      left_pix;
  int unsigned      upleft_pix;
  int unsigned      col_next;
  bit               in_top_row;

  gradient_t        pending_gradients [$];
  int               gradient_errors;
  int               cycle_count;
  bit               tx_calm;
  bit               rx_calm;
  int               rx_hold;
  int               rx_draw;
  gradient_t        rx_due;

  // directed stimulus, expected values typed in where obvious
  stim_row_t directed_rows [25] = '{
    '{ROW_PIXEL, 13'd255,  1'b1, 1'b1, 11'd1020, 1'b0},
    '{ROW_PIXEL, 13'd0,    1'b0, 1'b1, 11'd1020, 1'b0},
    '{ROW_PIXEL, 13'd255,  1'b0, 1'b1, 11'd1020, 1'b0},
    '{ROW_WIDTH, 13'd2,    1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd0,    1'b1, 1'b1, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd0,    1'b0, 1'b1, 11'd0,    1'b1},
    '{ROW_PIXEL, 13'd255,  1'b0, 1'b1, 11'd1020, 1'b0},
    '{ROW_PIXEL, 13'd255,  1'b0, 1'b1, 11'd1275, 1'b1},
    '{ROW_PIXEL, 13'd17,   1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd200,  1'b1, 1'b1, 11'd800,  1'b0},
    '{ROW_WIDTH, 13'd0,    1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd100,  1'b0, 1'b1, 11'd400,  1'b1},
    '{ROW_PIXEL, 13'd40,   1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_WIDTH, 13'd8191, 1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd1,    1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd128,  1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd254,  1'b1, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd127,  1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_WIDTH, 13'd3,    1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd64,   1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd8,    1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_WIDTH, 13'd4096, 1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd255,  1'b0, 1'b0, 11'd0,    1'b0},
    '{ROW_PIXEL, 13'd0,    1'b1, 1'b0, 11'd0,    1'b0},
    '{ROW_WIDTH, 13'd1,    1'b0, 1'b0, 11'd0,    1'b0}
  };

  roberts_gradient_magnitude_top u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_pixel               (in_pixel),
    .in_frame_start         (in_frame_start),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_magnitude_quarters (out_magnitude_quarters),
    .out_line_end           (out_line_end),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_line_width         (cfg_line_width)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // width as the block applies it
  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > ROW_MAX) return ROW_MAX;
    return width_reg;
  endfunction

  // true when the next pixel would read a store entry never written
  function automatic bit reads_unwritten();
    int unsigned x;
    x = col_next;
    if (x >= active_width()) x = active_width() - 1;
    return !in_top_row && !row_written[x];
  endfunction

  // gradient of one pixel, advancing the predictor state
  function automatic void predict_gradient(input logic [PIX_W-1:0] pix, input logic fs,
                                           output gradient_t res);
    int unsigned w, x, up, ul, lf, da, db;
    w = active_width();
    if (fs) begin
      col_next   = 0;
      in_top_row = 1'b1;
      left_pix   = 0;
      upleft_pix = 0;
    end
    x = col_next;
    if (x >= w) x = w - 1;
    up = in_top_row ? 0 : row_mem[x];
    ul = (x == 0) ? 0 : upleft_pix;
    lf = (x == 0) ? 0 : left_pix;
    da = (pix >= ul) ? pix - ul : ul - pix;
    db = (lf >= up) ? lf - up : up - lf;
    res.magnitude_quarters = MAG_W'((da > db) ? 4 * da + db : 4 * db + da);
    res.line_end = (x + 1 >= w);
    row_mem[x]     = pix;
    row_written[x] = 1'b1;
    if (res.line_end) begin
      col_next   = 0;
      in_top_row = 1'b0;
      left_pix   = 0;
      upleft_pix = 0;
    end else begin
      col_next   = x + 1;
      left_pix   = pix;
      upleft_pix = up;
    end
  endfunction

  // drain the block completely
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_gradients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // line width write, only while drained
  task automatic write_width(input logic [CFG_W-1:0] w);
    settle();
    cfg_valid      <= 1'b1;
    cfg_line_width <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = w;
  endtask

  // one pixel transaction; typed values override the predictor
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs, input bit typed,
                            input logic [MAG_W-1:0] t_mag, input logic t_le);
    int gap;
    gradient_t due;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // never let a row read a store entry that was never written
    if (!fs && reads_unwritten()) fs = 1'b1;
    predict_gradient(pix, fs, due);
    if (typed) begin
      due.magnitude_quarters = t_mag;
      due.line_end           = t_le;
    end
    pending_gradients.push_back(due);
    in_valid       <= 1'b1;
    in_pixel       <= pix;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // result receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_gradients.size() == 0) begin
          $error("unexpected result: magnitude_quarters %0d, line_end %0d",
                 out_magnitude_quarters, out_line_end);
          gradient_errors++;
        end else begin
          rx_due = pending_gradients.pop_front();
          if (out_magnitude_quarters !== rx_due.magnitude_quarters) begin
            $error("magnitude_quarters: expected %0d, actual %0d",
                   rx_due.magnitude_quarters, out_magnitude_quarters);
            gradient_errors++;
          end
          if (out_line_end !== rx_due.line_end) begin
            $error("line_end: expected %0d, actual %0d", rx_due.line_end, out_line_end);
            gradient_errors++;
          end
        end
        rx_draw = rx_calm ? 0 : $urandom_range(0, 16);
        rx_hold   <= rx_draw;
        out_stall <= (rx_draw != 0);
      end else if (rx_hold > 1) begin
        rx_hold <= rx_hold - 1;
      end else begin
        rx_hold   <= 0;
        out_stall <= 1'b0;
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL roberts_gradient_magnitude_top");
      $finish;
    end
  end

  // stimulus
  initial begin
    int random_items;
    int n;
    logic fs;
    logic [CFG_W-1:0] w;

    gradient_errors = 0;
    random_items    = 0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    width_reg       = LINE_WIDTH_RESET;
    col_next        = 0;
    in_top_row      = 1'b1;
    left_pix        = 0;
    upleft_pix      = 0;
    foreach (row_written[i]) row_written[i] = 1'b0;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel       <= '0;
    in_frame_start <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_line_width <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WIDTH)
        write_width(directed_rows[r].value);
      else
        send_pixel(directed_rows[r].value[PIX_W-1:0], directed_rows[r].frame_start,
                   directed_rows[r].typed, directed_rows[r].magnitude_quarters,
                   directed_rows[r].line_end);
    end

    // random frames, drained between phases
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 5))
              0: w = 13'd0;
              1: w = 13'd1;
              2: w = 13'd4096;
              3: w = 13'd8191;
              4: w = 13'd640;
              default: w = 13'd4095;
            endcase
          end
          1, 2: w = CFG_W'($urandom_range(9, 64));
          default: w = CFG_W'($urandom_range(1, 8));
        endcase
        write_width(w);
      end else begin
        settle();
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 48);
      for (int i = 0; i < n; i++) begin
        fs = (i == 0 && $urandom_range(0, 3) != 0) || ($urandom_range(0, 63) == 0);
        send_pixel(pick_pixel(), fs, 1'b0, '0, 1'b0);
        random_items++;
      end
    end

    settle();
    if (gradient_errors == 0)
      $display("PASS roberts_gradient_magnitude_top");
    else
      $display("FAIL roberts_gradient_magnitude_top");
    $finish;
  end

endmodule
